@@ rtl/ncm_pkg.sv @@
`timescale 1ns / 1ps

package ncm_pkg;

	// table size and tail reserve
	localparam int MAX_DATAGRAMS = 64;
	localparam int TAIL_RESERVE  = 2048;

	// transfer block layout
	localparam logic [31:0] NTH32_SIGNATURE = 32'h686D636E;
	localparam logic [31:0] NDP32_SIGNATURE = 32'h306D636E;
	localparam int NTH32_SIZE   = 16;
	localparam int NDP32_SIZE   = 16;
	localparam int ENTRY_BYTES  = 8;
	localparam int FIRST_ENTRY  = 32;
	localparam int HDR_RAW      = FIRST_ENTRY + ENTRY_BYTES + MAX_DATAGRAMS * ENTRY_BYTES;
	localparam logic [19:0] OFFSET_MAX = 20'hFFFFF;

	// derived widths
	localparam int CNT_W   = $clog2(MAX_DATAGRAMS + 1);
	localparam int ENTRY_W = $clog2(FIRST_ENTRY + ENTRY_BYTES * (MAX_DATAGRAMS + 1) + 1);

	// configuration register indexes
	localparam logic [1:0] CFG_NTB_MAX_SIZE      = 2'd0;
	localparam logic [1:0] CFG_PAYLOAD_DIVISOR   = 2'd1;
	localparam logic [1:0] CFG_PAYLOAD_REMAINDER = 2'd2;

	// input operation codes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [1:0] {
		WK_STORE16 = 2'd0,
		WK_STORE32 = 2'd1,
		WK_FILL    = 2'd2,
		WK_PLACE   = 2'd3
	} write_kind_t;

	typedef enum logic [1:0] {
		JOB_FIRST  = 2'd0,
		JOB_ADD    = 2'd1,
		JOB_REJECT = 2'd2,
		JOB_FINISH = 2'd3
	} job_kind_t;

	typedef struct packed {
		logic [17:0] ntb_max_size;
		logic [11:0] payload_divisor;
		logic [10:0] payload_remainder;
	} cfg_t;

	// everything needed to emit the results of one transaction
	typedef struct packed {
		job_kind_t          kind;
		logic [ENTRY_W-1:0] entry;
		logic [19:0]        place;
		logic [15:0]        len;
		logic [19:0]        area;
		logic [20:0]        blen;
		logic [15:0]        ndp_len;
		logic [ENTRY_W-1:0] term_off;
		logic               acc;
	} job_t;

	typedef struct packed {
		write_kind_t kind;
		logic [17:0] offset;
		logic [31:0] value;
		logic        accept_more;
		logic        rejected;
		logic        last;
	} res_t;

endpackage

@@ rtl/ncm_plan.sv @@
`timescale 1ns / 1ps

module ncm_plan import ncm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        take,
	input  logic        operation,
	input  logic [15:0] datagram_length,
	output job_t        job,
	output logic        job_has
);

	logic [CNT_W-1:0]   count_q;
	logic [19:0]        run_q;
	logic [ENTRY_W-1:0] next_entry_q;
	logic [17:0]        waterline_q;

	logic               first;
	logic               full;
	logic [19:0]        area;
	logic [17:0]        wl_new;
	logic [17:0]        wl;
	logic [19:0]        base;
	logic [19:0]        new_run;
	logic [CNT_W-1:0]   count_inc;
	logic [15:0]        count_x;

	// align up to the divisor, add the remainder, saturate to 20 bits
	function automatic logic [19:0] pad(input logic [20:0] x, input logic [11:0] div,
			input logic [10:0] rem);
		logic [11:0] m;
		logic [21:0] mask;
		logic [21:0] s;
		logic [22:0] v;
		m    = div - 12'd1;
		mask = (div == 12'd0) ? 22'd0 : ~{10'd0, m};
		s    = {1'b0, x} + {10'd0, m};
		v    = {1'b0, s & mask} + {12'd0, rem};
		return (v > {3'd0, OFFSET_MAX}) ? OFFSET_MAX : v[19:0];
	endfunction

	// plan of the transaction against the current block state
	always_comb begin
		first     = (count_q == '0);
		full      = (count_q >= CNT_W'(MAX_DATAGRAMS));
		area      = pad(21'(HDR_RAW), cfg.payload_divisor, cfg.payload_remainder);
		wl_new    = (cfg.ntb_max_size > 18'(TAIL_RESERVE))
		          ? cfg.ntb_max_size - 18'(TAIL_RESERVE) : 18'd0;
		wl        = first ? wl_new : waterline_q;
		base      = first ? area : run_q;
		new_run   = pad({1'b0, base} + {5'd0, datagram_length},
		                cfg.payload_divisor, cfg.payload_remainder);
		count_inc = count_q + CNT_W'(1);
		count_x   = 16'(count_q) + 16'd1;

		job.entry    = first ? ENTRY_W'(FIRST_ENTRY) : next_entry_q;
		job.place    = base;
		job.len      = datagram_length;
		job.area     = area;
		job.ndp_len  = 16'(NDP32_SIZE) + (count_x << 3);
		job.term_off = next_entry_q;
		job.acc      = !(({2'd0, wl} < new_run) || (count_inc >= CNT_W'(MAX_DATAGRAMS)));

		if (operation == OP_FINISH) begin
			job.kind = JOB_FINISH;
			job.blen = {1'b0, run_q};
			job_has  = !first;
		end else if (full) begin
			job.kind = JOB_REJECT;
			job.blen = {1'b0, run_q};
			job_has  = 1'b1;
		end else begin
			job.kind = first ? JOB_FIRST : JOB_ADD;
			job.blen = {1'b0, area} + {5'd0, datagram_length};
			job_has  = 1'b1;
		end
	end

	// block state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			run_q        <= '0;
			next_entry_q <= '0;
			waterline_q  <= '0;
		end else if (take) begin
			if (operation == OP_FINISH) begin
				count_q <= '0;
			end else if (!full) begin
				count_q      <= count_inc;
				run_q        <= new_run;
				next_entry_q <= job.entry + ENTRY_W'(ENTRY_BYTES);
				if (first) begin
					waterline_q <= wl_new;
				end
			end
		end
	end

endmodule

@@ rtl/ncm_emit.sv @@
`timescale 1ns / 1ps

module ncm_emit import ncm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job_in,
	input  logic job_load,
	output logic job_free,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);

	job_t        job_q;
	logic        job_valid_q;
	logic [3:0]  step_q;
	res_t        res_q;
	logic        res_valid_q;

	logic        load_out;
	logic [3:0]  final_step;
	logic        at_final;
	logic [3:0]  idx;
	res_t        cur;

	assign load_out = !res_valid_q || res_ready;

	// index of the final result per job kind
	always_comb begin
		case (job_q.kind)
			JOB_FIRST:  final_step = 4'd8;
			JOB_ADD:    final_step = 4'd2;
			JOB_REJECT: final_step = 4'd0;
			JOB_FINISH: final_step = 4'd2;
			default:    final_step = 4'd0;
		endcase
		at_final = (step_q == final_step);
		job_free = !job_valid_q || (load_out && at_final);
	end

	// result selected by job kind and step
	always_comb begin
		idx             = (job_q.kind == JOB_ADD) ? step_q + 4'd6 : step_q;
		cur.kind        = WK_STORE32;
		cur.offset      = '0;
		cur.value       = '0;
		cur.accept_more = job_q.acc;
		cur.rejected    = 1'b0;
		cur.last        = at_final;
		case (job_q.kind)
			JOB_REJECT: begin
				cur.kind        = WK_STORE16;
				cur.accept_more = 1'b0;
				cur.rejected    = 1'b1;
			end
			JOB_FINISH: begin
				cur.accept_more = 1'b1;
				case (step_q)
					4'd0: begin
						cur.kind   = WK_STORE32;
						cur.offset = 18'd8;
						cur.value  = 32'(job_q.blen);
					end
					4'd1: begin
						cur.kind   = WK_STORE16;
						cur.offset = 18'(NDP32_SIZE + 4);
						cur.value  = 32'(job_q.ndp_len);
					end
					default: begin
						cur.kind   = WK_FILL;
						cur.offset = 18'(job_q.term_off);
						cur.value  = 32'(ENTRY_BYTES);
					end
				endcase
			end
			default: begin
				case (idx)
					4'd0: begin
						cur.kind  = WK_FILL;
						cur.value = 32'(job_q.area);
					end
					4'd1: begin
						cur.value = NTH32_SIGNATURE;
					end
					4'd2: begin
						cur.kind   = WK_STORE16;
						cur.offset = 18'd4;
						cur.value  = 32'(NTH32_SIZE);
					end
					4'd3: begin
						cur.offset = 18'd8;
						cur.value  = 32'(job_q.blen);
					end
					4'd4: begin
						cur.offset = 18'd12;
						cur.value  = 32'(NTH32_SIZE);
					end
					4'd5: begin
						cur.offset = 18'(NTH32_SIZE);
						cur.value  = NDP32_SIGNATURE;
					end
					4'd6: begin
						cur.offset = 18'(job_q.entry);
						cur.value  = 32'(job_q.place);
					end
					4'd7: begin
						cur.offset = 18'(job_q.entry) + 18'd4;
						cur.value  = 32'(job_q.len);
					end
					default: begin
						cur.kind   = WK_PLACE;
						cur.offset = job_q.place[17:0];
						cur.value  = 32'(job_q.len);
					end
				endcase
			end
		endcase
	end

	// job register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (job_valid_q && load_out) begin
				step_q <= at_final ? 4'd0 : step_q + 4'd1;
			end
			if (job_load) begin
				job_valid_q <= 1'b1;
			end else if (job_free) begin
				job_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= job_in;
		end
		if (job_valid_q && load_out) begin
			res_q <= cur;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= job_valid_q;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

@@ rtl/ncm_ntb32_frame_builder.sv @@
`timescale 1ns / 1ps

// NCM 32-bit transfer block builder
// slave stream: one transaction per add (tuser low) carrying a datagram length
// in tdata, or per finish (tuser high). master stream: buffer writes, tuser the
// write kind, tdata offset, value and status flags, tlast on the final write
// of each input transaction. cfg_we/cfg_addr/cfg_wdata set max block size,
// payload divisor and payload remainder; write only while idle.
// the first write of a transaction passes through the job register and then the
// output register before it is offered.
// one write per cycle while the receiver does not stall; an input transaction
// makes nine writes for the first add of a block, three for other adds and
// for a finish, one for a refused add and none for an empty finish; the result
// sequencer steps through them from the job register.
// the next input is taken in the cycle its predecessor's last write is loaded
// into the output register, so input and output overlap.
// reset clears the block state, the step counter and the valid flags of the job
// and output registers, and restores the default configuration.
// when the receiver stalls the output register holds, the sequencer waits and
// s_axis_tready drops once the job register is occupied.

module ncm_ntb32_frame_builder import ncm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [17:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] datagram_length
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [17:0] write_offset, [49:18] write_value,
	                                    // [50] accept_more, [51] rejected, [55:52] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] write_kind
	output logic        m_axis_tlast
);

	cfg_t cfg_q;
	job_t job;
	logic job_has;
	logic job_free;
	logic take;
	res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ntb_max_size      <= 18'd16384;
			cfg_q.payload_divisor   <= 12'd4;
			cfg_q.payload_remainder <= 11'd2;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_NTB_MAX_SIZE:      cfg_q.ntb_max_size      <= cfg_wdata;
				CFG_PAYLOAD_DIVISOR:   cfg_q.payload_divisor   <= cfg_wdata[11:0];
				CFG_PAYLOAD_REMAINDER: cfg_q.payload_remainder <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = job_free;
	assign take          = s_axis_tvalid && job_free;

	ncm_plan u_plan (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.take            (take),
		.operation       (s_axis_tuser),
		.datagram_length (s_axis_tdata),
		.job             (job),
		.job_has         (job_has)
	);

	ncm_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_in    (job),
		.job_load  (take && job_has),
		.job_free  (job_free),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	// output packing
	assign m_axis_tdata = {4'd0, res.rejected, res.accept_more, res.value, res.offset};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule
